/* design/md5_pkg.sv */
// ============================================================================
// md5_pkg
// Shared types, initial chaining words and round tables for the MD5 core.
// ============================================================================
`default_nettype none

package md5_pkg;

    typedef logic [3:0][31:0] t_quad;

    // Status of the round unit; the sequencer also addresses the block buffer from it.
    typedef struct packed {
        logic       busy;
        logic       last;
        logic [5:0] round;
    } t_rnd_stat;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // Message word used in each round.
    function automatic logic [3:0] md5_g(input logic [5:0] round);
        logic [3:0] i;
        logic [3:0] g;
        i = round[3:0];
        case (round[5:4])
            2'd0:    g = i;
            2'd1:    g = (i << 2) + i + 4'd1;
            2'd2:    g = (i << 1) + i + 4'd5;
            2'd3:    g = (i << 3) - i;
            default: g = i;
        endcase
        return g;
    endfunction

    // Left rotation amount of each round.
    function automatic logic [4:0] md5_rot(input logic [5:0] round);
        logic [4:0] s;
        case ({round[5:4], round[1:0]})
            4'd0:    s = 5'd7;
            4'd1:    s = 5'd12;
            4'd2:    s = 5'd17;
            4'd3:    s = 5'd22;
            4'd4:    s = 5'd5;
            4'd5:    s = 5'd9;
            4'd6:    s = 5'd14;
            4'd7:    s = 5'd20;
            4'd8:    s = 5'd4;
            4'd9:    s = 5'd11;
            4'd10:   s = 5'd16;
            4'd11:   s = 5'd23;
            4'd12:   s = 5'd6;
            4'd13:   s = 5'd10;
            4'd14:   s = 5'd15;
            4'd15:   s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // Additive constant of each round.
    function automatic logic [31:0] md5_k(input logic [5:0] round);
        logic [31:0] k;
        case (round)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* design/md5_round.sv */
// ============================================================================
// md5_round
// Shared MD5 round unit: holds the working words and runs one round a cycle.
// ============================================================================
`default_nettype none

module md5_round (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire md5_pkg::t_quad    i_chain,
    input  wire logic [31:0]       i_msg_word,
    output md5_pkg::t_rnd_stat     o_stat,
    output md5_pkg::t_quad         o_work
);
    import md5_pkg::*;

    logic [31:0] r_a, r_b, r_c, r_d;
    logic        r_busy;
    logic [5:0]  r_round;

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] new_b;

    always_comb begin
        case (r_round[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_d & r_b) | (~r_d & r_c);
            2'd2:    f = r_b ^ r_c ^ r_d;
            2'd3:    f = r_c ^ (r_b | ~r_d);
            default: f = r_b ^ r_c ^ r_d;
        endcase
        sum      = r_a + f + md5_k(r_round) + i_msg_word;
        rot_wide = {sum, sum} << md5_rot(r_round);
        new_b    = r_b + rot_wide[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 6'd0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_round <= 6'd0;
        end else if (r_busy) begin
            r_round <= r_round + 6'd1;
            if (r_round == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_chain[0];
            r_b <= i_chain[1];
            r_c <= i_chain[2];
            r_d <= i_chain[3];
        end else if (r_busy) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= new_b;
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.last  = r_busy && (r_round == 6'd63);
    assign o_stat.round = r_round;
    assign o_work       = {r_d, r_c, r_b, r_a};

endmodule

`default_nettype wire

/* design/md5_block_buf.sv */
// ============================================================================
// md5_block_buf
// Sixteen-word block buffer: byte-lane writes, one registered word read per
// round, addressed one round ahead.
// ============================================================================
`default_nettype none

module md5_block_buf (
    input  wire logic        i_clk,
    input  wire logic        i_wr_en,
    input  wire logic [5:0]  i_wr_pos,
    input  wire logic [7:0]  i_wr_byte,
    input  wire logic [3:0]  i_rd_idx,
    output logic [31:0]      o_rd_word
);
    // Bytes land little-endian, so lane 0 holds the first byte of a word.
    logic [3:0][7:0] r_words [16];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_words[i_wr_pos[5:2]][i_wr_pos[1:0]] <= i_wr_byte;
        end
        o_rd_word <= r_words[i_rd_idx];
    end

endmodule

`default_nettype wire

/* design/md5_message_digest.sv */
// ============================================================================
// md5_message_digest
// Streaming MD5: one message byte per input beat, 128-bit digest per message.
// ============================================================================
// Input channel: i_in_valid / o_in_stall carry one beat with i_msg_byte,
// i_byte_present and i_final_item. A beat with i_final_item set ends the
// message; a final beat with no byte ends an empty message.
// Output channel: o_out_valid / i_out_stall carry one beat per message with
// the four little-endian digest words.
// Input flow: a byte beat is taken whenever the core is idle. Every 64th
// byte starts a compression that holds off input (64 rounds through the
// one shared round unit, then the chaining add). The final beat adds 9 to
// 72 padding bytes, written one per cycle while no compression runs, plus
// one or two compressions, then the load of the output register.
// The digest sits in an output register, so the next message is taken
// while a result still waits; if a second digest is ready before the first
// is taken, the core holds with input stalled until the output frees up.
// Reset (synchronous, active low) returns the chaining words to the MD5
// initial values, clears the byte count and drops o_out_valid.
// ============================================================================
`default_nettype none

module md5_message_digest (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [7:0]   i_msg_byte,
    input  wire logic         i_byte_present,
    input  wire logic         i_final_item,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic [31:0]       o_digest_word0,
    output logic [31:0]       o_digest_word1,
    output logic [31:0]       o_digest_word2,
    output logic [31:0]       o_digest_word3
);
    import md5_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,   // taking message beats
        S_PAD  = 5'b00010,   // writing padding and length bytes
        S_COMP = 5'b00100,   // rounds running in the shared unit
        S_ADD  = 5'b01000,   // folding working words into the chain
        S_OUT  = 5'b10000    // waiting to load the output register
    } t_state;

    t_state      r_state, n_state;
    t_quad       r_chain, n_chain;
    logic [63:0] r_count, n_count;
    logic [5:0]  r_fill, n_fill;
    logic        r_fin, n_fin;       // message ended, padding in progress
    logic        r_first, n_first;   // next pad byte is the 0x80 marker
    logic        r_len, n_len;       // pad position has reached the length field
    logic        r_done, n_done;     // the compression running is the last one
    logic        r_out_valid, n_out_valid;
    t_quad       r_digest, n_digest;

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        rnd_start;
    logic [31:0] msg_word;
    t_quad       work;
    t_rnd_stat   rnd_stat;
    logic        in_accept;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;
    logic [5:0]  rd_round;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Length field is the byte count in bits, stored little-endian in the
    // last eight bytes of the final block.
    assign len_bits = {r_count[60:0], 3'b000};
    assign len_byte = len_bits[{r_fill[2:0], 3'b000} +: 8];
    assign pad_byte = r_first ? PAD_MARK : (r_len ? len_byte : 8'h00);

    // The block buffer read is registered, so it is addressed with the
    // round that runs in the next cycle.
    assign rd_round = rnd_start ? 6'd0 : (rnd_stat.round + 6'd1);

    always_comb begin
        n_state     = r_state;
        n_chain     = r_chain;
        n_count     = r_count;
        n_fill      = r_fill;
        n_fin       = r_fin;
        n_first     = r_first;
        n_len       = r_len;
        n_done      = r_done;
        n_out_valid = r_out_valid;
        n_digest    = r_digest;
        wr_en       = 1'b0;
        wr_byte     = i_msg_byte;
        rnd_start   = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_byte_present) begin
                        wr_en   = 1'b1;
                        n_fill  = r_fill + 6'd1;
                        n_count = r_count + 64'd1;
                    end
                    if (i_byte_present && (r_fill == 6'd63)) begin
                        // Block is full: compress first, pad afterwards if final.
                        rnd_start = 1'b1;
                        n_fin     = i_final_item;
                        n_first   = i_final_item;
                        n_len     = 1'b0;
                        n_done    = 1'b0;
                        n_state   = S_COMP;
                    end else if (i_final_item) begin
                        n_fin   = 1'b1;
                        n_first = 1'b1;
                        n_len   = 1'b0;
                        n_done  = 1'b0;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                wr_en   = 1'b1;
                wr_byte = pad_byte;
                n_fill  = r_fill + 6'd1;
                n_first = 1'b0;
                if (r_fill == 6'd55) begin
                    n_len = 1'b1;
                end
                if (r_fill == 6'd63) begin
                    // Wrapping after a length byte means the message is done.
                    rnd_start = 1'b1;
                    n_done    = r_len;
                    n_len     = 1'b0;
                    n_state   = S_COMP;
                end
            end
            S_COMP: begin
                if (rnd_stat.last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int k = 0; k < 4; k++) begin
                    n_chain[k] = r_chain[k] + work[k];
                end
                if (r_done) begin
                    n_state = S_OUT;
                end else if (r_fin) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_digest    = r_chain;
                    n_out_valid = 1'b1;
                    n_chain     = {IV_D, IV_C, IV_B, IV_A};
                    n_count     = 64'd0;
                    n_fill      = 6'd0;
                    n_fin       = 1'b0;
                    n_first     = 1'b0;
                    n_len       = 1'b0;
                    n_done      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chain     <= {IV_D, IV_C, IV_B, IV_A};
            r_count     <= 64'd0;
            r_fill      <= 6'd0;
            r_fin       <= 1'b0;
            r_first     <= 1'b0;
            r_len       <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_fin       <= n_fin;
            r_first     <= n_first;
            r_len       <= n_len;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digest <= n_digest;
    end

    md5_block_buf u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_pos  (r_fill),
        .i_wr_byte (wr_byte),
        .i_rd_idx  (md5_g(rd_round)),
        .o_rd_word (msg_word)
    );

    md5_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rnd_start),
        .i_chain    (r_chain),
        .i_msg_word (msg_word),
        .o_stat     (rnd_stat),
        .o_work     (work)
    );

    assign o_out_valid    = r_out_valid;
    assign o_digest_word0 = r_digest[0];
    assign o_digest_word1 = r_digest[1];
    assign o_digest_word2 = r_digest[2];
    assign o_digest_word3 = r_digest[3];

endmodule

`default_nettype wire

/* sim/md5_message_digest_tb.sv */
// ============================================================================
// md5_message_digest_tb
// Checks the streaming MD5 core against a digest predictor kept in the
// bench. Short directed messages come first, then random messages whose
// lengths favor the padding edges. Both channels idle at random.
// ============================================================================
`timescale 1ns / 1ps

module md5_message_digest_tb;

    import md5_pkg::*;

    // One input beat as the driver sees it. A set hold_off flag keeps the
    // beat back until every digest already owed has been taken.
    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       ends_msg;
        bit         hold_off;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_msg_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_final_item = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_digest_word0;
    logic [31:0] o_digest_word1;
    logic [31:0] o_digest_word2;
    logic [31:0] o_digest_word3;

    md5_message_digest u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_msg_byte     (i_msg_byte),
        .i_byte_present (i_byte_present),
        .i_final_item   (i_final_item),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_digest_word0 (o_digest_word0),
        .o_digest_word1 (o_digest_word1),
        .o_digest_word2 (o_digest_word2),
        .o_digest_word3 (o_digest_word3)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Digest predictor. It mirrors the core's architectural state: chaining
    // words, the sixteen-word block being filled, the byte count and the fill
    // position within the block.
    // ------------------------------------------------------------------------
    logic [31:0] round_k [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotation amounts: four per group of sixteen rounds.
    int unsigned round_shift [0:15] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    logic [31:0] chain [0:3] = '{IV_A, IV_B, IV_C, IV_D};
    logic [31:0] blk [0:15];
    logic [63:0] msg_bytes = '0;
    logic [5:0]  fill_pos = '0;

    // Digests owed by the core, oldest first.
    t_quad digest_q [$];

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // One full 64-round compression of blk into the chaining words.
    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, t;
        int          g;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                f = (b & c) | (~b & d);
                g = r;
            end else if (r < 32) begin
                f = (d & b) | (~d & c);
                g = (5 * r + 1) % 16;
            end else if (r < 48) begin
                f = b ^ c ^ d;
                g = (3 * r + 5) % 16;
            end else begin
                f = c ^ (b | ~d);
                g = (7 * r) % 16;
            end
            t = d;
            d = c;
            c = b;
            b = b + rol32(a + f + round_k[r] + blk[g], round_shift[(r / 16) * 4 + r % 4]);
            a = t;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
    endfunction

    // Bytes go in little-endian. A word is cleared as its first byte lands,
    // so nothing left over from an earlier block can leak into this one.
    function automatic void pack_byte(input logic [7:0] v);
        if (fill_pos[1:0] == 2'd0) begin
            blk[fill_pos[5:2]] = '0;
        end
        blk[fill_pos[5:2]][8 * fill_pos[1:0] +: 8] = v;
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0) begin
            compress_block();
        end
    endfunction

    // Runs one accepted beat through the predictor. A final beat pads the
    // message out, queues the digest and starts the next message afresh.
    function automatic void absorb_beat(input t_beat bt);
        logic [63:0] bit_len;
        t_quad       dig;
        if (bt.has_byte) begin
            pack_byte(bt.data);
            msg_bytes = msg_bytes + 64'd1;
        end
        if (bt.ends_msg) begin
            bit_len = msg_bytes << 3;
            pack_byte(PAD_MARK);
            while (fill_pos != 6'd56) begin
                pack_byte(8'h00);
            end
            for (int j = 0; j < 8; j++) begin
                pack_byte(bit_len[8 * j +: 8]);
            end
            for (int j = 0; j < 4; j++) begin
                dig[j] = chain[j];
            end
            digest_q.push_back(dig);
            chain[0] = IV_A;
            chain[1] = IV_B;
            chain[2] = IV_C;
            chain[3] = IV_D;
            msg_bytes = '0;
            fill_pos = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus store and message builders.
    // ------------------------------------------------------------------------
    t_beat beat_q [$];
    int    beats_queued = 0;

    function automatic void add_beat(input logic [7:0] data, input logic has_byte,
                                     input logic ends_msg, input bit hold_off);
        t_beat bt;
        bt.data = data;
        bt.has_byte = has_byte;
        bt.ends_msg = ends_msg;
        bt.hold_off = hold_off;
        beat_q.push_back(bt);
        beats_queued++;
    endfunction

    // Queues one random message of len bytes. The last byte either rides on
    // the final beat or is followed by a final beat without a byte. Now and
    // then a beat that carries nothing is slipped in; the core must ignore
    // it. Returns the number of beats that do something.
    function automatic int add_message(input int len, input bit hold_off);
        bit fold;
        int n;
        fold = (len > 0) && ($urandom_range(1) == 1);
        n = fold ? len - 1 : len;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 4) begin
                add_beat(8'($urandom_range(255)), 1'b0, 1'b0, hold_off);
                hold_off = 1'b0;
            end
            add_beat(8'($urandom_range(255)), 1'b1, 1'b0, hold_off);
            hold_off = 1'b0;
        end
        add_beat(8'($urandom_range(255)), fold, 1'b1, hold_off);
        return n + 1;
    endfunction

    // Lengths lean toward short messages, with a good share right at the
    // points where the length field spills into a second padding block or
    // where a block fills exactly.
    function automatic int pick_length();
        int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            return $urandom_range(12);
        end else if (r < 75) begin
            return $urandom_range(54, 13);
        end else if (r < 90) begin
            return edges[$urandom_range(9)];
        end else begin
            return $urandom_range(130, 100);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver. It presents the next queued beat whenever the input channel is
    // free, idling about one cycle in six except during the calm stretch.
    // Each beat is handed to the predictor at the edge where it is accepted.
    // ------------------------------------------------------------------------
    t_beat on_wire;
    int    beats_taken = 0;
    logic  calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                absorb_beat(on_wire);
                beats_taken <= beats_taken + 1;
            end
            // The calm stretch: neither side idles for a few hundred beats.
            calm <= (beats_taken >= 400) && (beats_taken < 700);
            if (!i_in_valid || !o_in_stall) begin
                if (beat_q.size() != 0 && !(beat_q[0].hold_off && digest_q.size() != 0)
                    && (calm || $urandom_range(99) >= 17)) begin
                    on_wire = beat_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_msg_byte <= on_wire.data;
                    i_byte_present <= on_wire.has_byte;
                    i_final_item <= on_wire.ends_msg;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every digest beat taken is checked word by word against the
    // oldest digest owed. The stall toggles at random outside the calm stretch.
    // ------------------------------------------------------------------------
    int err_count = 0;

    always @(posedge i_clk) begin
        t_quad got;
        t_quad want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_digest_word3, o_digest_word2, o_digest_word1, o_digest_word0};
                if (digest_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("%0t: digest beat with none owed: %h %h %h %h", $realtime,
                                 got[0], got[1], got[2], got[3]);
                    end
                end else begin
                    want = digest_q.pop_front();
                    if (got[0] !== want[0] || got[1] !== want[1] ||
                        got[2] !== want[2] || got[3] !== want[3]) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("%0t: digest mismatch: expected %h %h %h %h actual %h %h %h %h",
                                     $realtime, want[0], want[1], want[2], want[3],
                                     got[0], got[1], got[2], got[3]);
                        end
                    end
                end
            end
            i_out_stall <= !calm && ($urandom_range(99) < 17);
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        int counted;
        int msg_idx;

        // Directed messages. The empty message; a lone beat that carries
        // nothing ahead of a one-byte message; the byte extremes each on a
        // final beat; a short text ended by a bare final beat; an ignored
        // beat in the middle of a message; two empty messages back to back;
        // and a run of edge byte values.
        add_beat(8'h00, 1'b0, 1'b1, 1'b0);
        add_beat(8'ha5, 1'b0, 1'b0, 1'b0);
        add_beat(8'h00, 1'b1, 1'b1, 1'b0);
        add_beat(8'hff, 1'b1, 1'b1, 1'b0);
        add_beat(8'h61, 1'b1, 1'b0, 1'b0);
        add_beat(8'h62, 1'b1, 1'b0, 1'b0);
        add_beat(8'h63, 1'b1, 1'b0, 1'b0);
        add_beat(8'h5a, 1'b0, 1'b1, 1'b0);
        add_beat(8'h6d, 1'b1, 1'b0, 1'b0);
        add_beat(8'hc3, 1'b0, 1'b0, 1'b0);
        add_beat(8'h64, 1'b1, 1'b0, 1'b0);
        add_beat(8'h35, 1'b1, 1'b1, 1'b0);
        add_beat(8'hff, 1'b0, 1'b1, 1'b0);
        add_beat(8'h00, 1'b0, 1'b1, 1'b0);
        add_beat(8'hff, 1'b1, 1'b0, 1'b0);
        add_beat(8'h00, 1'b1, 1'b0, 1'b0);
        add_beat(8'h80, 1'b1, 1'b0, 1'b0);
        add_beat(8'h7f, 1'b1, 1'b0, 1'b0);
        add_beat(8'h01, 1'b1, 1'b0, 1'b0);
        add_beat(8'hfe, 1'b1, 1'b0, 1'b0);
        add_beat(8'h55, 1'b1, 1'b1, 1'b0);

        // Random messages. Every so often a message waits until the core has
        // handed over every digest owed, so it starts from a fully idle core.
        counted = 0;
        msg_idx = 0;
        while (counted < 1300) begin
            counted += add_message(pick_length(), (msg_idx % 12) == 0);
            msg_idx++;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken != beats_queued) begin
            @(posedge i_clk);
        end
        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        // A final beat can take two compressions plus padding; give any
        // stray digest beat ample time to show up.
        repeat (300) @(posedge i_clk);

        if (err_count == 0 && digest_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
design/md5_pkg.sv
design/md5_round.sv
design/md5_block_buf.sv
design/md5_message_digest.sv
sim/md5_message_digest_tb.sv
